@@ rtl/ardp_pkg.sv @@
// ----------------------------------------------------------------------------
// ardp_pkg
// Shared types, codes and helpers for the ARM data-processing execute block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ardp_pkg;

	localparam int unsigned WordW  = 32;
	localparam int unsigned NumRegs = 16;
	localparam int unsigned RegIdxW = $clog2(NumRegs);
	localparam int unsigned FlagsW  = 4;

	// flag bit positions in NZCV
	localparam int unsigned FlagNBit = 3;
	localparam int unsigned FlagZBit = 2;
	localparam int unsigned FlagCBit = 1;
	localparam int unsigned FlagVBit = 0;

	typedef enum logic [3:0] {
		OP_AND = 4'd0,
		OP_EOR = 4'd1,
		OP_SUB = 4'd2,
		OP_RSB = 4'd3,
		OP_ADD = 4'd4,
		OP_TST = 4'd8,
		OP_TEQ = 4'd9,
		OP_CMP = 4'd10,
		OP_ORR = 4'd12,
		OP_MOV = 4'd13
	} opcode_t;

	typedef enum logic [3:0] {
		COND_EQ = 4'd0,
		COND_NE = 4'd1,
		COND_CS = 4'd2,
		COND_CC = 4'd3,
		COND_MI = 4'd4,
		COND_PL = 4'd5,
		COND_VS = 4'd6,
		COND_VC = 4'd7,
		COND_HI = 4'd8,
		COND_LS = 4'd9,
		COND_GE = 4'd10,
		COND_LT = 4'd11,
		COND_GT = 4'd12,
		COND_LE = 4'd13,
		COND_AL = 4'd14,
		COND_NV = 4'd15
	} cond_t;

	typedef enum logic [1:0] {
		SH_LSL = 2'd0,
		SH_LSR = 2'd1,
		SH_ASR = 2'd2,
		SH_ROR = 2'd3
	} shift_t;

	// ALU outcome handed from the execute logic to the pipeline
	typedef struct packed {
		logic               executed;
		logic               write_enable;
		logic               bad_opcode;
		logic [WordW-1:0]   result_value;
		logic [FlagsW-1:0]  flags_nzcv;
	} alu_res_t;

	function automatic logic cond_pass(input logic [3:0] cond, input logic [FlagsW-1:0] f);
		logic n, z, c, v, p;
		n = f[FlagNBit];
		z = f[FlagZBit];
		c = f[FlagCBit];
		v = f[FlagVBit];
		case (cond_t'(cond))
			COND_EQ: p = z;
			COND_NE: p = !z;
			COND_CS: p = c;
			COND_CC: p = !c;
			COND_MI: p = n;
			COND_PL: p = !n;
			COND_VS: p = v;
			COND_VC: p = !v;
			COND_HI: p = c && !z;
			COND_LS: p = !c || z;
			COND_GE: p = (n == v);
			COND_LT: p = (n != v);
			COND_GT: p = !z && (n == v);
			COND_LE: p = z || (n != v);
			COND_AL: p = 1'b1;
			default: p = 1'b0;
		endcase
		return p;
	endfunction

endpackage

@@ rtl/ardp_insn_if.sv @@
// ----------------------------------------------------------------------------
// ardp_insn_if
// Instruction channel: valid/ready handshake with one instruction word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ardp_insn_if
	import ardp_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [WordW-1:0] instruction_word;

	modport source (output valid, output instruction_word, input ready);
	modport sink   (input valid, input instruction_word, output ready);
endinterface

@@ rtl/ardp_res_if.sv @@
// ----------------------------------------------------------------------------
// ardp_res_if
// Result channel: valid/ready handshake with the execute outcome.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ardp_res_if
	import ardp_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               executed;
	logic               write_enable;
	logic [RegIdxW-1:0] dest_index;
	logic [WordW-1:0]   result_value;
	logic [FlagsW-1:0]  flags_nzcv;
	logic               bad_opcode;

	modport source (
		output valid, output executed, output write_enable, output dest_index,
		output result_value, output flags_nzcv, output bad_opcode, input ready
	);
	modport sink (
		input valid, input executed, input write_enable, input dest_index,
		input result_value, input flags_nzcv, input bad_opcode, output ready
	);
endinterface

@@ rtl/ardp_alu.sv @@
// ----------------------------------------------------------------------------
// ardp_alu
// Condition check, operand2 shifter and ALU for one data-processing word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ardp_alu
	import ardp_pkg::*;
(
	input  logic [WordW-1:0]  insn,
	input  logic [WordW-1:0]  rn_val,
	input  logic [WordW-1:0]  rm_val,
	input  logic [WordW-1:0]  rs_val,
	input  logic [FlagsW-1:0] flags,
	output alu_res_t          res
);

	logic              cin;
	logic [3:0]        op_raw;
	logic              supported;
	logic              passed;
	logic              s_bit;

	// immediate form
	logic [4:0]        imm_rot;
	logic [WordW-1:0]  imm_ext;
	logic [2*WordW-1:0] imm_dbl;
	logic [WordW-1:0]  imm_val;

	// register form
	shift_t            sh_type;
	logic [7:0]        amt;
	logic              rrx;
	logic [WordW:0]    lsl_t;
	logic [WordW:0]    lsr_t;
	logic [WordW:0]    asr_t;
	logic [2*WordW-1:0] ror_t;
	logic [WordW-1:0]  sh_val;
	logic              sh_c;

	logic [WordW-1:0]  op2;
	logic              op2_c;

	// adder
	logic              is_sub;
	logic [WordW-1:0]  add_x;
	logic [WordW-1:0]  add_y;
	logic [WordW:0]    add_sum;

	logic [WordW-1:0]  alu_val;
	logic              alu_c;
	logic              logical;
	logic              writes;

	assign cin    = flags[FlagCBit];
	assign op_raw = insn[24:21];
	assign s_bit  = insn[20];
	assign supported = op_raw inside {OP_AND, OP_EOR, OP_SUB, OP_RSB, OP_ADD,
		OP_TST, OP_TEQ, OP_CMP, OP_ORR, OP_MOV};
	assign passed = cond_pass(insn[31:28], flags);

	// rotated 8-bit immediate
	assign imm_rot = {insn[11:8], 1'b0};
	assign imm_ext = {{(WordW-8){1'b0}}, insn[7:0]};
	assign imm_dbl = {imm_ext, imm_ext} >> imm_rot;
	assign imm_val = imm_dbl[WordW-1:0];

	// shift amount: low byte of Rs or the 5-bit field
	always_comb begin
		sh_type = shift_t'(insn[6:5]);
		rrx     = 1'b0;
		if (insn[4]) begin
			amt = rs_val[7:0];
		end else begin
			amt = {3'b000, insn[11:7]};
			if (insn[11:7] == 5'd0) begin
				if (sh_type == SH_LSR || sh_type == SH_ASR) begin
					amt = 8'd32;
				end else if (sh_type == SH_ROR) begin
					rrx = 1'b1;
				end
			end
		end
	end

	assign lsl_t = {1'b0, rm_val} << amt[4:0];
	assign lsr_t = {rm_val, 1'b0} >> amt[4:0];
	assign asr_t = $unsigned($signed({rm_val, 1'b0}) >>> amt[4:0]);
	assign ror_t = {rm_val, rm_val} >> amt[4:0];

	// barrel shifter with register-form range handling
	always_comb begin
		sh_val = rm_val;
		sh_c   = cin;
		if (rrx) begin
			sh_val = {cin, rm_val[WordW-1:1]};
			sh_c   = rm_val[0];
		end else if (amt != 8'd0) begin
			case (sh_type)
				SH_LSL: begin
					if (amt < 8'd32) begin
						sh_val = lsl_t[WordW-1:0];
						sh_c   = lsl_t[WordW];
					end else begin
						sh_val = '0;
						sh_c   = (amt == 8'd32) ? rm_val[0] : 1'b0;
					end
				end
				SH_LSR: begin
					if (amt < 8'd32) begin
						sh_val = lsr_t[WordW:1];
						sh_c   = lsr_t[0];
					end else begin
						sh_val = '0;
						sh_c   = (amt == 8'd32) ? rm_val[WordW-1] : 1'b0;
					end
				end
				SH_ASR: begin
					if (amt < 8'd32) begin
						sh_val = asr_t[WordW:1];
						sh_c   = asr_t[0];
					end else begin
						sh_val = {WordW{rm_val[WordW-1]}};
						sh_c   = rm_val[WordW-1];
					end
				end
				default: begin
					sh_val = ror_t[WordW-1:0];
					sh_c   = ror_t[WordW-1];
				end
			endcase
		end
	end

	// operand2 select
	always_comb begin
		if (insn[25]) begin
			op2   = imm_val;
			op2_c = (imm_rot == 5'd0) ? cin : imm_val[WordW-1];
		end else begin
			op2   = sh_val;
			op2_c = sh_c;
		end
	end

	// one adder for ADD, SUB, RSB, CMP; carry out is NOT borrow on subtract
	assign is_sub  = (op_raw == OP_SUB) || (op_raw == OP_RSB) || (op_raw == OP_CMP);
	assign add_x   = (op_raw == OP_RSB) ? op2 : rn_val;
	assign add_y   = (op_raw == OP_RSB) ? rn_val : op2;
	assign add_sum = {1'b0, add_x} + {1'b0, (is_sub ? ~add_y : add_y)}
		+ {{WordW{1'b0}}, is_sub};

	always_comb begin
		logical = 1'b1;
		writes  = 1'b1;
		case (opcode_t'(op_raw))
			OP_AND: alu_val = rn_val & op2;
			OP_EOR: alu_val = rn_val ^ op2;
			OP_SUB, OP_RSB, OP_ADD: begin
				alu_val = add_sum[WordW-1:0];
				logical = 1'b0;
			end
			OP_TST: begin
				alu_val = rn_val & op2;
				writes  = 1'b0;
			end
			OP_TEQ: begin
				alu_val = rn_val ^ op2;
				writes  = 1'b0;
			end
			OP_CMP: begin
				alu_val = add_sum[WordW-1:0];
				logical = 1'b0;
				writes  = 1'b0;
			end
			OP_ORR: alu_val = rn_val | op2;
			default: alu_val = op2;
		endcase
		alu_c = logical ? op2_c : add_sum[WordW];
	end

	// outcome; nothing changes unless executed
	always_comb begin
		res.bad_opcode   = !supported;
		res.executed     = supported && passed;
		res.write_enable = res.executed && writes;
		res.result_value = res.executed ? alu_val : '0;
		res.flags_nzcv   = flags;
		if (res.executed && s_bit) begin
			res.flags_nzcv[FlagNBit] = alu_val[WordW-1];
			res.flags_nzcv[FlagZBit] = (alu_val == '0);
			res.flags_nzcv[FlagCBit] = alu_c;
		end
	end

endmodule

@@ rtl/arm_data_processing_execute.sv @@
// ----------------------------------------------------------------------------
// arm_data_processing_execute
// Steps: register file read on transfer, then execute into the output register.
// Throughput: one instruction per cycle unless the result channel stalls; the
// register file read overlaps the previous write, closed by a bypass.
// Reset: asynchronous; flags clear at once, register entries read as zero until
// first written (per-entry valid bits), pipeline and output empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arm_data_processing_execute
	import ardp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	ardp_insn_if.sink    insn,
	ardp_res_if.source   res
);

	// register file: two copies give three read ports
	logic [WordW-1:0]   regfile_a_q [NumRegs];
	logic [WordW-1:0]   regfile_b_q [NumRegs];
	logic [NumRegs-1:0] written_q;

	logic               in_xfer;
	logic [RegIdxW-1:0] rn_addr;
	logic [RegIdxW-1:0] rm_addr;
	logic [RegIdxW-1:0] rs_addr;

	// stage 1: read data arrives, execute
	logic               valid_s1;
	logic [WordW-1:0]   insn_s1;
	logic [WordW-1:0]   rn_data_s1;
	logic [WordW-1:0]   rm_data_s1;
	logic [WordW-1:0]   rs_data_s1;
	logic               rn_ok_s1;
	logic               rm_ok_s1;
	logic               rs_ok_s1;
	logic               adv_s1;

	// last write, for the read that overlapped it
	logic               wb_valid_q;
	logic [RegIdxW-1:0] wb_idx_q;
	logic [WordW-1:0]   wb_data_q;

	logic [FlagsW-1:0]  flags_q;

	logic [WordW-1:0]   rn_val;
	logic [WordW-1:0]   rm_val;
	logic [WordW-1:0]   rs_val;
	alu_res_t           alu_out;
	logic [RegIdxW-1:0] rd_idx;

	// output register
	logic               out_valid_q;
	logic               out_executed_q;
	logic               out_we_q;
	logic [RegIdxW-1:0] out_dest_q;
	logic [WordW-1:0]   out_result_q;
	logic [FlagsW-1:0]  out_flags_q;
	logic               out_bad_q;

	function automatic logic [WordW-1:0] resolve(
		input logic [RegIdxW-1:0] idx,
		input logic [WordW-1:0]   mem_data,
		input logic               ok,
		input logic               wbv,
		input logic [RegIdxW-1:0] wbi,
		input logic [WordW-1:0]   wbd
	);
		logic [WordW-1:0] v;
		if (wbv && (wbi == idx)) begin
			v = wbd;
		end else if (ok) begin
			v = mem_data;
		end else begin
			v = '0;
		end
		return v;
	endfunction

	// handshake
	assign adv_s1    = valid_s1 && (!out_valid_q || res.ready);
	assign insn.ready = !valid_s1 || adv_s1;
	assign in_xfer   = insn.valid && insn.ready;

	assign rn_addr = insn.instruction_word[19:16];
	assign rm_addr = insn.instruction_word[3:0];
	assign rs_addr = insn.instruction_word[11:8];

	// register file write
	always_ff @(posedge clk) begin
		if (adv_s1 && alu_out.write_enable) begin
			regfile_a_q[rd_idx] <= alu_out.result_value;
			regfile_b_q[rd_idx] <= alu_out.result_value;
		end
	end

	// register file read, registered on transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			rn_data_s1 <= regfile_a_q[rn_addr];
			rm_data_s1 <= regfile_a_q[rm_addr];
			rs_data_s1 <= regfile_b_q[rs_addr];
			rn_ok_s1   <= written_q[rn_addr];
			rm_ok_s1   <= written_q[rm_addr];
			rs_ok_s1   <= written_q[rs_addr];
			insn_s1    <= insn.instruction_word;
		end
	end

	// control: stage valid, written bits, flags, bypass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			written_q  <= '0;
			flags_q    <= '0;
			wb_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				flags_q <= alu_out.flags_nzcv;
				if (alu_out.write_enable) begin
					written_q[rd_idx] <= 1'b1;
					wb_valid_q        <= 1'b1;
				end
			end
		end
	end

	// bypass payload
	always_ff @(posedge clk) begin
		if (adv_s1 && alu_out.write_enable) begin
			wb_idx_q  <= rd_idx;
			wb_data_q <= alu_out.result_value;
		end
	end

	// operand fetch with bypass of the write that overlapped the read
	assign rn_val = resolve(insn_s1[19:16], rn_data_s1, rn_ok_s1, wb_valid_q, wb_idx_q, wb_data_q);
	assign rm_val = resolve(insn_s1[3:0], rm_data_s1, rm_ok_s1, wb_valid_q, wb_idx_q, wb_data_q);
	assign rs_val = resolve(insn_s1[11:8], rs_data_s1, rs_ok_s1, wb_valid_q, wb_idx_q, wb_data_q);
	assign rd_idx = insn_s1[15:12];

	ardp_alu u_alu (
		.insn   (insn_s1),
		.rn_val (rn_val),
		.rm_val (rm_val),
		.rs_val (rs_val),
		.flags  (flags_q),
		.res    (alu_out)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_executed_q <= alu_out.executed;
			out_we_q       <= alu_out.write_enable;
			out_dest_q     <= rd_idx;
			out_result_q   <= alu_out.result_value;
			out_flags_q    <= alu_out.flags_nzcv;
			out_bad_q      <= alu_out.bad_opcode;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.executed     = out_executed_q;
	assign res.write_enable = out_we_q;
	assign res.dest_index   = out_dest_q;
	assign res.result_value = out_result_q;
	assign res.flags_nzcv   = out_flags_q;
	assign res.bad_opcode   = out_bad_q;

endmodule
